// ----- hw/rtl/msa_pkg.sv -----
// ----------------------------------------------------------------------------
// msa_pkg - shared definitions for the multichannel sample accumulator
// function codes, widths, block depth and the scan control bundle
// ----------------------------------------------------------------------------
package msa_pkg;

    localparam int DEPTH        = 16;   // full scans per published block
    localparam int MAX_CHANNELS = 16;   // channel count saturates here
    localparam int NUM_SLOTS    = 16;   // sum storage entries
    localparam int SAMPLE_W     = 12;
    localparam int SUM_W        = 16;
    localparam int CH_W         = 4;
    localparam int CNT_W        = 5;
    localparam int ROUND_W      = 4;
    localparam int FUNC_W       = 2;
    localparam int AVG_SHIFT    = $clog2(DEPTH);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE   = 2'd0,
        FUNC_READ_AVG = 2'd1,
        FUNC_READ_SUM = 2'd2,
        FUNC_STATUS   = 2'd3
    } t_func;

    // scan controller to sum bank
    typedef struct packed {
        logic             restart;    // channel count written, clear running sums
        logic             sample_en;  // add sample at pos this cycle
        logic             block_end;  // last sample of the block, publish and clear
        logic [CH_W-1:0]  pos;        // channel addressed by the current sample
        logic [CNT_W-1:0] active;     // effective channel count, 1 to MAX_CHANNELS
    } t_scan_ctl;

endpackage

// ----- hw/rtl/msa_scan.sv -----
// ----------------------------------------------------------------------------
// msa_scan - round-robin scan controller
// holds the channel count, scan position and scan round, flags block end
// ----------------------------------------------------------------------------
module msa_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [msa_pkg::CNT_W-1:0]   i_cfg_wr_data,
    input  logic                        i_sample_en,
    output msa_pkg::t_scan_ctl          o_ctl
);

    logic [msa_pkg::CNT_W-1:0]   r_chan_count;
    logic [msa_pkg::CH_W-1:0]    r_pos;
    logic [msa_pkg::ROUND_W-1:0] r_round;

    logic [msa_pkg::CNT_W-1:0]   active;
    logic [msa_pkg::CH_W-1:0]    pos_eff;
    logic [msa_pkg::CNT_W-1:0]   pos_next;
    logic [msa_pkg::ROUND_W:0]   round_next;
    logic                        wrap;
    logic                        last_round;

    always_comb begin
        if (r_chan_count == '0) begin
            active = msa_pkg::CNT_W'(1);
        end else if (r_chan_count > msa_pkg::CNT_W'(msa_pkg::MAX_CHANNELS)) begin
            active = msa_pkg::CNT_W'(msa_pkg::MAX_CHANNELS);
        end else begin
            active = r_chan_count;
        end
        pos_eff    = ({1'b0, r_pos} >= active) ? '0 : r_pos;
        pos_next   = {1'b0, pos_eff} + msa_pkg::CNT_W'(1);
        wrap       = (pos_next >= active);
        round_next = {1'b0, r_round} + (msa_pkg::ROUND_W+1)'(1);
        last_round = !(round_next < (msa_pkg::ROUND_W+1)'(msa_pkg::DEPTH));

        o_ctl.restart   = i_cfg_wr_en;
        o_ctl.sample_en = i_sample_en;
        o_ctl.block_end = i_sample_en && wrap && last_round;
        o_ctl.pos       = pos_eff;
        o_ctl.active    = active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_count <= msa_pkg::CNT_W'(1);
            r_pos        <= '0;
            r_round      <= '0;
        end else if (i_cfg_wr_en) begin
            r_chan_count <= i_cfg_wr_data;
            r_pos        <= '0;
            r_round      <= '0;
        end else if (i_sample_en) begin
            if (wrap) begin
                r_pos   <= '0;
                r_round <= last_round ? '0 : round_next[msa_pkg::ROUND_W-1:0];
            end else begin
                r_pos   <= pos_next[msa_pkg::CH_W-1:0];
            end
        end
    end

endmodule

// ----- hw/rtl/msa_bank.sv -----
// ----------------------------------------------------------------------------
// msa_bank - running and published sum registers
// accumulates samples, publishes at block end, muxes the read channel
// ----------------------------------------------------------------------------
module msa_bank (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  msa_pkg::t_scan_ctl            i_ctl,
    input  logic [msa_pkg::SAMPLE_W-1:0]  i_sample_value,
    input  logic [msa_pkg::CH_W-1:0]      i_read_channel,
    output logic [msa_pkg::SUM_W-1:0]     o_pub_sum
);

    logic [msa_pkg::SUM_W-1:0] r_running [msa_pkg::NUM_SLOTS];
    logic [msa_pkg::SUM_W-1:0] r_published [msa_pkg::NUM_SLOTS];
    logic [msa_pkg::SUM_W-1:0] n_running [msa_pkg::NUM_SLOTS];

    // running sum after this cycle's sample, before any block-end clear
    always_comb begin
        for (int i = 0; i < msa_pkg::NUM_SLOTS; i++) begin
            if (i_ctl.sample_en && (i_ctl.pos == msa_pkg::CH_W'(i))) begin
                n_running[i] = r_running[i]
                             + msa_pkg::SUM_W'(i_sample_value);
            end else begin
                n_running[i] = r_running[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < msa_pkg::NUM_SLOTS; i++) begin
                r_running[i]   <= '0;
                r_published[i] <= '0;
            end
        end else begin
            for (int i = 0; i < msa_pkg::NUM_SLOTS; i++) begin
                if (i_ctl.restart || i_ctl.block_end) begin
                    r_running[i] <= '0;
                end else begin
                    r_running[i] <= n_running[i];
                end
                // channels above the count keep their published sums
                if (!i_ctl.restart && i_ctl.block_end
                        && (msa_pkg::CNT_W'(i) < i_ctl.active)) begin
                    r_published[i] <= n_running[i];
                end
            end
        end
    end

    assign o_pub_sum = r_published[i_read_channel];

endmodule

// ----- hw/rtl/multichannel_sample_accumulator_top.sv -----
// ----------------------------------------------------------------------------
// multichannel_sample_accumulator_top - oversampling averager over a channel scan
// flow: an item is registered on accept, its result is registered when the item retires
// throughput: one item per cycle while the result side does not stall, set by the sum update on the input register
// sample items give no result, read and status items give one each
// reset: synchronous active low, clears all sums, scan counters, ready flag, count to 1
// ----------------------------------------------------------------------------
module multichannel_sample_accumulator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write, channel count
    input  logic                          i_cfg_wr_en,
    input  logic [msa_pkg::CNT_W-1:0]     i_cfg_wr_data,
    // input item channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [msa_pkg::FUNC_W-1:0]    i_func,
    input  logic [msa_pkg::SAMPLE_W-1:0]  i_sample_value,
    input  logic [msa_pkg::CH_W-1:0]      i_read_channel,
    // result item channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [msa_pkg::SUM_W-1:0]     o_read_data
);

    // input register
    logic                          r_in_valid;
    msa_pkg::t_func                r_func;
    logic [msa_pkg::SAMPLE_W-1:0]  r_sample;
    logic [msa_pkg::CH_W-1:0]      r_channel;

    // result register and ready flag
    logic                          r_out_valid;
    logic [msa_pkg::SUM_W-1:0]     r_out_data;
    logic                          r_ready;

    logic                          out_free;
    logic                          has_result;
    logic                          proc_go;
    logic                          in_take;
    logic                          sample_en;
    logic                          block_end;
    logic [msa_pkg::SUM_W-1:0]     pub_sum;
    logic [msa_pkg::SUM_W-1:0]     n_out_data;
    msa_pkg::t_scan_ctl            scan_ctl;

    // item in the input register retires when its result slot is free, a sample item needs no slot
    assign out_free   = !r_out_valid || !i_stall;
    assign has_result = (r_func != msa_pkg::FUNC_SAMPLE);
    assign proc_go    = r_in_valid && (!has_result || out_free);
    assign in_take    = !r_in_valid || proc_go;
    assign o_stall    = !in_take;
    assign sample_en  = proc_go && !has_result;

    msa_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_sample_en   (sample_en),
        .o_ctl         (scan_ctl)
    );

    assign block_end = scan_ctl.block_end;

    msa_bank u_bank (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (scan_ctl),
        .i_sample_value (r_sample),
        .i_read_channel (r_channel),
        .o_pub_sum      (pub_sum)
    );

    // read data: flag, average or raw sum, zero for a channel above the count
    always_comb begin
        case (r_func)
            msa_pkg::FUNC_STATUS: begin
                n_out_data = msa_pkg::SUM_W'(r_ready);
            end
            msa_pkg::FUNC_READ_AVG: begin
                if ({1'b0, r_channel} < scan_ctl.active) begin
                    n_out_data = pub_sum >> msa_pkg::AVG_SHIFT;
                end else begin
                    n_out_data = '0;
                end
            end
            msa_pkg::FUNC_READ_SUM: begin
                if ({1'b0, r_channel} < scan_ctl.active) begin
                    n_out_data = pub_sum;
                end else begin
                    n_out_data = '0;
                end
            end
            default: begin
                n_out_data = '0;
            end
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_valid) begin
            r_func    <= msa_pkg::t_func'(i_func);
            r_sample  <= i_sample_value;
            r_channel <= i_read_channel;
        end
    end

    // ready flag, set at block end, cleared by a status item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else if (block_end) begin
            r_ready <= 1'b1;
        end else if (proc_go && (r_func == msa_pkg::FUNC_STATUS)) begin
            r_ready <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go && has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && has_result) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;

endmodule

// ----- dv/tb_multichannel_sample_accumulator_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multichannel_sample_accumulator_top - self-checking bench for the averager
// drives sample, read and status items with random gaps and receiver stalls,
// tracks sums, scan position and ready flag in a behavioral predictor and
// compares every returned read_data with the predicted value in order
// ----------------------------------------------------------------------------
module tb_multichannel_sample_accumulator_top;

    import msa_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int SETTLE_CYCLES  = 4;        // a sample item retires in the cycle after accept
    localparam int HOLD_CYCLES    = 120;      // long receiver hold-off
    localparam int TIMEOUT_CYCLES = 400_000;
    localparam int MAX_REPORTS    = 10;

    // dut inputs, all known from time zero
    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_cfg_wr_en    = 1'b0;
    logic [CNT_W-1:0]    i_cfg_wr_data  = '0;
    logic                i_valid        = 1'b0;
    logic [FUNC_W-1:0]   i_func         = FUNC_SAMPLE;
    logic [SAMPLE_W-1:0] i_sample_value = '0;
    logic [CH_W-1:0]     i_read_channel = '0;
    logic                i_stall        = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [SUM_W-1:0]    o_read_data;

    // predictor state: the averager as seen from outside
    logic [CNT_W-1:0] acc_count;
    logic [SUM_W-1:0] acc_running   [NUM_SLOTS];
    logic [SUM_W-1:0] acc_published [NUM_SLOTS];
    int               acc_pos;
    int               acc_round;
    bit               acc_ready;

    // read_data values still owed by the dut, oldest first
    logic [SUM_W-1:0] pending_read_data [$];

    // run bookkeeping
    int mismatches       = 0;
    int items_sent       = 0;
    int samples_sent     = 0;
    int results_checked  = 0;
    int blocks_published = 0;

    // idling control shared between the test tasks and the two sides
    bit tx_steady     = 1'b0;
    bit rx_steady     = 1'b0;
    int hold_requests = 0;

    // 10 ns clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    multichannel_sample_accumulator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_sample_value (i_sample_value),
        .i_read_channel (i_read_channel),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_read_data    (o_read_data)
    );

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // zero counts as one channel, anything above the maximum saturates
    function automatic int active_of(input logic [CNT_W-1:0] count);
        if (count == 0)
            return 1;
        if (count > MAX_CHANNELS)
            return MAX_CHANNELS;
        return int'(count);
    endfunction

    // scan restarts on reset and on every count write, published sums survive
    task automatic clear_scan_model();
        for (int k = 0; k < NUM_SLOTS; k++)
            acc_running[k] = '0;
        acc_pos   = 0;
        acc_round = 0;
    endtask

    // applies one accepted item, returns the read_data it owes if any
    task automatic update_averager(input t_func f, input logic [SAMPLE_W-1:0] s,
                                   input logic [CH_W-1:0] ch, output bit has_data,
                                   output logic [SUM_W-1:0] data);
        int n;
        n        = active_of(acc_count);
        has_data = 1'b1;
        data     = '0;
        case (f)
            FUNC_SAMPLE: begin
                has_data = 1'b0;
                if (acc_pos >= n)
                    acc_pos = 0;
                acc_running[acc_pos] = acc_running[acc_pos] + s;
                acc_pos++;
                if (acc_pos >= n) begin
                    // one full scan done
                    acc_pos = 0;
                    if (acc_round + 1 < DEPTH) begin
                        acc_round++;
                    end else begin
                        // end of block: publish active channels only
                        for (int k = 0; k < n; k++)
                            acc_published[k] = acc_running[k];
                        for (int k = 0; k < NUM_SLOTS; k++)
                            acc_running[k] = '0;
                        acc_round = 0;
                        acc_ready = 1'b1;
                        blocks_published++;
                    end
                end
            end
            FUNC_STATUS: begin
                // read and clear the ready flag
                data      = SUM_W'(acc_ready);
                acc_ready = 1'b0;
            end
            default: begin
                // channels at or above the count read as zero
                if (ch < n) begin
                    data = acc_published[ch];
                    if (f == FUNC_READ_AVG)
                        data = data / DEPTH;
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(24, 6);
    endfunction

    // offers one item, holds it while stalled, predicts on accept
    task automatic send_item(input t_func f, input logic [SAMPLE_W-1:0] s,
                             input logic [CH_W-1:0] ch);
        bit               has_data;
        logic [SUM_W-1:0] data;
        int               gap;
        i_func         <= f;
        i_sample_value <= s;
        i_read_channel <= ch;
        i_valid        <= 1'b1;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        update_averager(f, s, ch, has_data, data);
        if (has_data)
            pending_read_data.push_back(data);
        items_sent++;
        if (f == FUNC_SAMPLE)
            samples_sent++;
        // valid stays up when the next item follows back to back
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering, let every owed result out, then let sample items settle
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (pending_read_data.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // count write only while the block is idle
    task automatic write_channel_count(input logic [CNT_W-1:0] value);
        drain_pipeline();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        acc_count = value;
        clear_scan_model();
    endtask

    // random phase: samples, reads and status items in the given mix, reads mostly on
    // active channels, some on any channel
    task automatic run_random_items(input int n, input int sample_pct,
                                    input int steady_items);
        t_func               f;
        logic [SAMPLE_W-1:0] s;
        logic [CH_W-1:0]     ch;
        int                  r;
        int                  read_pct;
        int                  i;
        read_pct = 100 - sample_pct;
        for (i = 0; i < n; i++) begin
            // an opening stretch with no idling on either side
            tx_steady = (i < steady_items);
            rx_steady = (i < steady_items);
            r = $urandom_range(99);
            if (r < sample_pct)
                f = FUNC_SAMPLE;
            else if (r < sample_pct + read_pct * 2 / 5)
                f = FUNC_READ_AVG;
            else if (r < sample_pct + read_pct * 4 / 5)
                f = FUNC_READ_SUM;
            else
                f = FUNC_STATUS;
            // full-scale and zero samples show up often
            r = $urandom_range(9);
            if (r == 0)
                s = '0;
            else if (r == 1)
                s = '1;
            else
                s = SAMPLE_W'($urandom_range(4095));
            if ($urandom_range(3) != 0)
                ch = CH_W'($urandom_range(active_of(acc_count) - 1));
            else
                ch = CH_W'($urandom_range(15));
            send_item(f, s, ch);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // receiver side: random stalls, plus a long hold on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_result_stall
        int stall_left;
        int hold_left;
        int hold_served;
        if (hold_requests != hold_served) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (rx_steady) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            // a stall run of random length starts now and then
            stall_left = ($urandom_range(3) == 0) ? pick_gap() : 0;
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checking, in order against the oldest owed value
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin : check_read_data
        logic [SUM_W-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_read_data.size() == 0) begin
                note_mismatch($sformatf("read_data %0d with nothing owed", o_read_data));
            end else begin
                want = pending_read_data.pop_front();
                results_checked++;
                if (o_read_data !== want)
                    note_mismatch($sformatf("read_data expected %0d got %0d",
                                            want, o_read_data));
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // everything reads zero after reset, channel 15 is inactive with count 1
    task automatic test_reset_state();
        send_item(FUNC_STATUS, '0, '0);
        send_item(FUNC_READ_AVG, '0, '0);
        send_item(FUNC_READ_SUM, '1, '0);
        send_item(FUNC_READ_SUM, '0, '1);
    endtask

    // one block of full-scale samples on the reset count of one channel,
    // largest sum, flag set then cleared by the first status read
    task automatic test_single_channel_block();
        repeat (DEPTH) send_item(FUNC_SAMPLE, '1, '0);
        send_item(FUNC_READ_SUM, '0, '0);
        send_item(FUNC_READ_AVG, '0, '0);
        send_item(FUNC_STATUS, '0, '0);
        send_item(FUNC_STATUS, '0, '0);
        send_item(FUNC_READ_AVG, '1, '1);
    endtask

    // all sixteen channels, enough samples for at least one block
    task automatic test_full_scan();
        write_channel_count(CNT_W'(MAX_CHANNELS));
        run_random_items(280, 95, 60);
    endtask

    // a count of zero behaves as one channel
    task automatic test_zero_count_as_one();
        write_channel_count('0);
        run_random_items(35, 65, 0);
    endtask

    // short scan, high channels keep their earlier published sums
    task automatic test_small_scan();
        write_channel_count(CNT_W'(3));
        run_random_items(80, 70, 0);
    endtask

    // rewriting the count mid-block throws the partial sums away
    task automatic test_restart_mid_block();
        write_channel_count(CNT_W'(5));
        run_random_items(20, 80, 0);
        write_channel_count(CNT_W'(5));
        run_random_items(50, 75, 0);
    endtask

    // counts above the maximum saturate, old high-channel sums read back
    task automatic test_saturated_count();
        write_channel_count(CNT_W'(17));
        run_random_items(20, 50, 0);
        write_channel_count('1);
        run_random_items(20, 50, 0);
    endtask

    // receiver holds off while reads keep coming, the input side must stall
    task automatic test_receiver_hold();
        hold_requests++;
        run_random_items(40, 20, 40);
    endtask

    // back to the reset count of one
    task automatic test_single_channel_random();
        write_channel_count(CNT_W'(1));
        run_random_items(15, 70, 0);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        // predictor matches the reset state
        acc_count = CNT_W'(1);
        acc_ready = 1'b0;
        for (int k = 0; k < NUM_SLOTS; k++)
            acc_published[k] = '0;
        clear_scan_model();

        // reset held at start, then released
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_single_channel_block();
        test_full_scan();
        test_zero_count_as_one();
        test_small_scan();
        test_restart_mid_block();
        test_saturated_count();
        test_receiver_hold();
        test_single_channel_random();

        drain_pipeline();

        $display("sent %0d items (%0d samples), checked %0d results, %0d blocks, %0d mismatches",
                 items_sent, samples_sent, results_checked, blocks_published, mismatches);
        $display("counts 0, 1, 3, 5, 16, 17 and 31, a mid-block restart, a %0d-cycle hold",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending_read_data.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("timeout with %0d results still owed", pending_read_data.size());
        $display("status: fail");
        $finish;
    end

endmodule
